// ----- design/slv3_pkg.sv -----
// ----------------------------------------------------------------------------
// slv3_pkg: shared types and widths for the 3x3 adjugate solver
// Fixed-point format, intermediate widths and the divider control word.
// ----------------------------------------------------------------------------
package slv3_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ELEM_W    = 32;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int COF_W     = PROD_W + 1;
    // Cofactor times element, three of them summed, with margin.
    localparam int DET_W     = COF_W + ELEM_W + 2;
    localparam int MAG_W     = DET_W + FRAC_BITS;
    // Quotient bits developed; one above the result width catches saturation.
    localparam int QBITS     = ELEM_W + 1;
    localparam int REM_W     = MAG_W + QBITS + 1;
    localparam int HALF_W    = ELEM_W;

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [COF_W-1:0]  t_cof;
    typedef logic signed [DET_W-1:0]  t_det;
    typedef logic        [DET_W-1:0]  t_dmag;
    typedef logic        [MAG_W-1:0]  t_nmag;
    typedef logic        [REM_W-1:0]  t_rem;
    typedef logic        [QBITS-1:0]  t_quo;

    typedef struct packed {
        logic singular;
        logic neg;
        logic pre_ovf;
    } t_div_ctl;

endpackage

// ----- design/slv3_cofactor.sv -----
// ----------------------------------------------------------------------------
// slv3_cofactor: cofactors of the transposed matrix
// Two stages: eighteen 32x32 products, then the nine signed differences.
// ----------------------------------------------------------------------------
module slv3_cofactor (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  slv3_pkg::t_elem [2:0][2:0]      i_m,
    input  slv3_pkg::t_elem [2:0]           i_v,
    output logic                            o_valid,
    output slv3_pkg::t_cof  [2:0][2:0]      o_cof,
    output slv3_pkg::t_elem [2:0]           o_m0,
    output slv3_pkg::t_elem [2:0]           o_v
);
    import slv3_pkg::*;

    t_prod [2:0][2:0] n_pa, n_pb, r_pa, r_pb;
    t_cof  [2:0][2:0] n_cof, r_cof;
    t_elem [2:0]      r_m0_a, r_m0_b, r_v_a, r_v_b;
    logic             r_valid_a, r_valid_b;

    // Cyclic index form gives the signed cofactor without a sign table.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_pa[r][c] = i_m[(r + 1) % 3][(c + 1) % 3] * i_m[(r + 2) % 3][(c + 2) % 3];
                n_pb[r][c] = i_m[(r + 1) % 3][(c + 2) % 3] * i_m[(r + 2) % 3][(c + 1) % 3];
                n_cof[r][c] = COF_W'(r_pa[r][c]) - COF_W'(r_pb[r][c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else if (i_en) begin
            r_valid_a <= i_valid;
            r_valid_b <= r_valid_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pa   <= n_pa;
            r_pb   <= n_pb;
            r_m0_a <= i_m[0];
            r_v_a  <= i_v;
            r_cof  <= n_cof;
            r_m0_b <= r_m0_a;
            r_v_b  <= r_v_a;
        end
    end

    assign o_valid = r_valid_b;
    assign o_cof   = r_cof;
    assign o_m0    = r_m0_b;
    assign o_v     = r_v_b;

endmodule

// ----- design/slv3_project.sv -----
// ----------------------------------------------------------------------------
// slv3_project: determinant and adjugate-times-vector numerators
// Split multiplies, recombine, sum, then magnitudes and signs for the divider.
// ----------------------------------------------------------------------------
module slv3_project (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  slv3_pkg::t_cof  [2:0][2:0]      i_cof,
    input  slv3_pkg::t_elem [2:0]           i_m0,
    input  slv3_pkg::t_elem [2:0]           i_v,
    output logic                            o_valid,
    output slv3_pkg::t_dmag                 o_dmag,
    output slv3_pkg::t_nmag [2:0]           o_nmag,
    output slv3_pkg::t_div_ctl [2:0]        o_ctl
);
    import slv3_pkg::*;

    // Index 3 holds the determinant terms, 0..2 the numerator terms.
    t_cof  [3:0][2:0]        w_c;
    t_elem [3:0][2:0]        w_x;
    logic signed [HALF_W+ELEM_W:0]   n_lo [4][3];
    logic signed [HALF_W+ELEM_W:0]   n_hi [4][3];
    logic signed [HALF_W+ELEM_W:0]   r_lo [4][3];
    logic signed [HALF_W+ELEM_W:0]   r_hi [4][3];
    t_det                        n_full [4][3];
    t_det                        r_full [4][3];
    t_det  [3:0]                 n_sum, r_sum;
    t_det  [2:0]                 w_nabs;
    t_nmag [2:0]                 n_nmag, r_nmag;
    t_dmag                       n_dmag, r_dmag;
    t_div_ctl [2:0]              n_ctl, r_ctl;
    logic  [3:0]                 r_valid;
    logic                        w_dneg, w_dzero;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_c[3][j] = i_cof[0][j];
            w_x[3][j] = i_m0[j];
            for (int i = 0; i < 3; i++) begin
                w_c[i][j] = i_cof[j][i];
                w_x[i][j] = i_v[j];
            end
        end
        for (int k = 0; k < 4; k++) begin
            for (int j = 0; j < 3; j++) begin
                n_lo[k][j] = $signed({1'b0, w_c[k][j][HALF_W-1:0]}) * w_x[k][j];
                n_hi[k][j] = $signed(w_c[k][j][COF_W-1:HALF_W]) * w_x[k][j];
                n_full[k][j] = (DET_W'(r_hi[k][j]) <<< HALF_W) + DET_W'(r_lo[k][j]);
            end
            n_sum[k] = r_full[k][0] + r_full[k][1] + r_full[k][2];
        end
        w_dneg  = r_sum[3][DET_W-1];
        w_dzero = (r_sum[3] == '0);
        n_dmag  = w_dneg ? t_dmag'(-r_sum[3]) : t_dmag'(r_sum[3]);
        for (int i = 0; i < 3; i++) begin
            w_nabs[i] = r_sum[i][DET_W-1] ? -r_sum[i] : r_sum[i];
            n_nmag[i] = MAG_W'(t_dmag'(w_nabs[i])) << FRAC_BITS;
            n_ctl[i].singular = w_dzero;
            n_ctl[i].neg      = r_sum[i][DET_W-1] ^ w_dneg;
            n_ctl[i].pre_ovf  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo   <= n_lo;
            r_hi   <= n_hi;
            r_full <= n_full;
            r_sum  <= n_sum;
            r_dmag <= n_dmag;
            r_nmag <= n_nmag;
            r_ctl  <= n_ctl;
        end
    end

    assign o_valid = r_valid[3];
    assign o_dmag  = r_dmag;
    assign o_nmag  = r_nmag;
    assign o_ctl   = r_ctl;

endmodule

// ----- design/slv3_divider.sv -----
// ----------------------------------------------------------------------------
// slv3_divider: pipelined restoring divider with Q16.16 saturation
// One quotient bit per stage, an overflow precheck first, saturation last.
// ----------------------------------------------------------------------------
module slv3_divider (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  slv3_pkg::t_dmag         i_dmag,
    input  slv3_pkg::t_nmag         i_nmag,
    input  slv3_pkg::t_div_ctl      i_ctl,
    output logic                    o_valid,
    output slv3_pkg::t_elem         o_res,
    output logic                    o_ovf,
    output logic                    o_singular
);
    import slv3_pkg::*;

    t_rem     r_rem [QBITS+1];
    t_quo     r_q   [QBITS+1];
    t_dmag    r_d   [QBITS+1];
    t_div_ctl r_ctl [QBITS+1];
    logic     [QBITS+1:0] r_valid;
    t_div_ctl n_ctl0;
    t_elem    n_res, r_res;
    logic     n_ovf, r_ovf, r_sing;
    logic     w_sat;
    t_quo     w_q;

    // A quotient of 2^QBITS or more saturates whatever its sign.
    always_comb begin
        n_ctl0 = i_ctl;
        n_ctl0.pre_ovf = (t_rem'(i_nmag) >= (t_rem'(i_dmag) << QBITS));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= t_rem'(i_nmag);
            r_q[0]   <= '0;
            r_d[0]   <= i_dmag;
            r_ctl[0] <= n_ctl0;
        end
    end

    for (genvar s = 0; s < QBITS; s++) begin : g_step
        logic [REM_W:0] w_trial;
        assign w_trial = {1'b0, r_rem[s]} - {1'b0, t_rem'(r_d[s]) << (QBITS - 1 - s)};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= w_trial[REM_W] ? r_rem[s] : w_trial[REM_W-1:0];
                r_q[s+1]   <= {r_q[s][QBITS-2:0], !w_trial[REM_W]};
                r_d[s+1]   <= r_d[s];
                r_ctl[s+1] <= r_ctl[s];
            end
        end
    end

    always_comb begin
        w_q = r_q[QBITS];
        if (r_ctl[QBITS].neg) begin
            w_sat = r_ctl[QBITS].pre_ovf || w_q[QBITS-1]
                || (w_q[ELEM_W-1] && (w_q[ELEM_W-2:0] != '0));
        end else begin
            w_sat = r_ctl[QBITS].pre_ovf || w_q[QBITS-1] || w_q[ELEM_W-1];
        end
        if (r_ctl[QBITS].singular) begin
            n_res = '0;
            n_ovf = 1'b0;
        end else if (w_sat) begin
            n_res = r_ctl[QBITS].neg ? {1'b1, {(ELEM_W-1){1'b0}}}
                                     : {1'b0, {(ELEM_W-1){1'b1}}};
            n_ovf = 1'b1;
        end else begin
            n_res = r_ctl[QBITS].neg ? -t_elem'(w_q[ELEM_W-1:0]) : t_elem'(w_q[ELEM_W-1:0]);
            n_ovf = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res  <= n_res;
            r_ovf  <= n_ovf;
            r_sing <= r_ctl[QBITS].singular;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[QBITS:0], i_valid};
        end
    end

    assign o_valid    = r_valid[QBITS+1];
    assign o_res      = r_res;
    assign o_ovf      = r_ovf;
    assign o_singular = r_sing;

endmodule

// ----- design/solve_3x3_by_adjugate.sv -----
// ----------------------------------------------------------------------------
// solve_3x3_by_adjugate: x = adj(M) * v / det(M) in Q16.16
// Streaming 3x3 linear solve with singular detection and saturation.
// ----------------------------------------------------------------------------
// The block accepts one request per clock while the output is not stalled and
// returns one result per request, in order. The pipeline holds two cofactor
// stages, four determinant and numerator stages, then the divider with a
// precheck, one quotient bit per stage over 33 stages and a saturation
// stage. All stages advance together whenever the output register is empty or
// being taken, so a stall on the output side holds the whole pipeline.
// ----------------------------------------------------------------------------
module solve_3x3_by_adjugate (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // row0_col0, row0_col1, .. row2_col2, vec_x, vec_y, vec_z (32 bits each)
    input  logic [383:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_x, out_y, out_z (32 bits each)
    output logic [95:0]  m_axis_tdata,
    // singular, overflow
    output logic [1:0]   m_axis_tuser
);
    import slv3_pkg::*;

    logic                  w_en;
    t_elem [2:0][2:0]      w_m;
    t_elem [2:0]           w_v;
    logic                  w_cof_valid, w_prj_valid;
    t_cof  [2:0][2:0]      w_cof;
    t_elem [2:0]           w_m0, w_v_d;
    t_dmag                 w_dmag;
    t_nmag [2:0]           w_nmag;
    t_div_ctl [2:0]        w_ctl;
    logic  [2:0]           w_dvalid, w_ovf, w_sing;
    t_elem [2:0]           w_res;

    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    // M is the transpose of the matrix as read.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                w_m[r][c] = s_axis_tdata[(3 * c + r) * ELEM_W +: ELEM_W];
            end
            w_v[r] = s_axis_tdata[(9 + r) * ELEM_W +: ELEM_W];
        end
    end

    slv3_cofactor u_cof (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_axis_tvalid),
        .i_m     (w_m),
        .i_v     (w_v),
        .o_valid (w_cof_valid),
        .o_cof   (w_cof),
        .o_m0    (w_m0),
        .o_v     (w_v_d)
    );

    slv3_project u_prj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_cof_valid),
        .i_cof   (w_cof),
        .i_m0    (w_m0),
        .i_v     (w_v_d),
        .o_valid (w_prj_valid),
        .o_dmag  (w_dmag),
        .o_nmag  (w_nmag),
        .o_ctl   (w_ctl)
    );

    for (genvar i = 0; i < 3; i++) begin : g_div
        slv3_divider u_div (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (w_en),
            .i_valid    (w_prj_valid),
            .i_dmag     (w_dmag),
            .i_nmag     (w_nmag[i]),
            .i_ctl      (w_ctl[i]),
            .o_valid    (w_dvalid[i]),
            .o_res      (w_res[i]),
            .o_ovf      (w_ovf[i]),
            .o_singular (w_sing[i])
        );
    end

    assign m_axis_tvalid = w_dvalid[0];
    assign m_axis_tdata  = {w_res[2], w_res[1], w_res[0]};
    assign m_axis_tuser  = {|w_ovf, w_sing[0]};

    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tuser[1])
        else $error("singular result not zero");

    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
            m_axis_tdata[31:0] == 32'h7FFFFFFF || m_axis_tdata[31:0] == 32'h80000000 ||
            m_axis_tdata[63:32] == 32'h7FFFFFFF || m_axis_tdata[63:32] == 32'h80000000 ||
            m_axis_tdata[95:64] == 32'h7FFFFFFF || m_axis_tdata[95:64] == 32'h80000000)
        else $error("overflow without a saturated component");

    // Data registers are not reset, so the flags are compared only on valid results.
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dvalid[0] == w_dvalid[1] && w_dvalid[1] == w_dvalid[2]
        && (!w_dvalid[0] || (w_sing[0] == w_sing[1] && w_sing[1] == w_sing[2])))
        else $error("divider lanes out of step");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule
